FILE: design/e2r_pkg.sv
// shared constants, types and functions for the euler to rotation matrix core
`default_nettype none
package e2r_pkg;

  localparam int WORK_FRAC    = 30;
  localparam int CORDIC_ITERS = 30;
  // working width: Q30 values stay within about +-1.7, products need 2x
  localparam int WW           = 34;
  localparam int PW           = 2 * WW;
  localparam int SUMW         = WW + 2;
  localparam logic signed [WW-1:0] CORDIC_GAIN = WW'(652032874);

  typedef logic signed [WW-1:0] work_t;

  function automatic logic signed [33:0] atan_phase(input int idx);
    logic signed [33:0] r;
    begin
      case (idx)
        0:  r = 34'sh020000000;
        1:  r = 34'sh012E4051E;
        2:  r = 34'sh009FB385B;
        3:  r = 34'sh0051111D4;
        4:  r = 34'sh0028B0D43;
        5:  r = 34'sh00145D7E1;
        6:  r = 34'sh000A2F61E;
        7:  r = 34'sh000517C55;
        8:  r = 34'sh00028BE53;
        9:  r = 34'sh000145F2F;
        10: r = 34'sh0000A2F98;
        11: r = 34'sh0000517CC;
        12: r = 34'sh000028BE6;
        13: r = 34'sh0000145F3;
        14: r = 34'sh00000A2FA;
        15: r = 34'sh00000517D;
        16: r = 34'sh0000028BE;
        17: r = 34'sh00000145F;
        18: r = 34'sh000000A30;
        19: r = 34'sh000000518;
        20: r = 34'sh00000028C;
        21: r = 34'sh000000146;
        22: r = 34'sh0000000A3;
        23: r = 34'sh000000051;
        24: r = 34'sh000000029;
        25: r = 34'sh000000014;
        26: r = 34'sh00000000A;
        27: r = 34'sh000000005;
        28: r = 34'sh000000003;
        29: r = 34'sh000000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // a*b rounded back to Q30, ties toward plus infinity (floor shift)
  function automatic work_t mul_q30(input work_t a, input work_t b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    begin
      p = PW'(a) * PW'(b);
      q = (p + (PW'(1) <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
      return q[WW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/e2r_cordic.sv
// pipelined rotation-mode cordic: one iteration per stage, sine and cosine out
`default_nettype none
module e2r_cordic import e2r_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output work_t                      sin_o,
  output work_t                      cos_o
);

  logic [31:0]      phase;
  logic [1:0]       quad;
  logic [31:0]      zr;

  work_t            x_r [CORDIC_ITERS+1];
  work_t            y_r [CORDIC_ITERS+1];
  logic signed [33:0] z_r [CORDIC_ITERS+1];
  logic [1:0]       q_r [CORDIC_ITERS+1];

  always_comb begin
    phase = 32'(angle) << (32 - ANGLE_BITS);
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    zr    = phase - (32'(quad) << 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= 34'(signed'(zr));
      q_r[0] <= quad;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_phase(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_phase(i);
        end
      end
    end
  end

  // quadrant swap and negate
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[CORDIC_ITERS])
        2'd0: begin cos_o <= x_r[CORDIC_ITERS];  sin_o <= y_r[CORDIC_ITERS];  end
        2'd1: begin cos_o <= -y_r[CORDIC_ITERS]; sin_o <= x_r[CORDIC_ITERS];  end
        2'd2: begin cos_o <= -x_r[CORDIC_ITERS]; sin_o <= -y_r[CORDIC_ITERS]; end
        default: begin cos_o <= y_r[CORDIC_ITERS]; sin_o <= -x_r[CORDIC_ITERS]; end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/e2r_matrix.sv
// matrix product stages: multiplier ranks one and two, then sum, round and saturate
`default_nettype none
module e2r_matrix import e2r_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire work_t                  sp, cp, sy, cy, sr, cr,
  output logic signed [FRAC_BITS+1:0] m_o [9]
);

  localparam int OW = FRAC_BITS + 2;
  localparam int SH = WORK_FRAC - FRAC_BITS;

  // rank one
  work_t spsy_r, cpsy_r, cycr_r, cysr_r, spcy_r, cpcy_r;
  work_t a_sp_r, a_cp_r, a_sr_r, a_cr_r, a_sy_r;
  // rank two
  work_t t21a_r, t21b_r, t22a_r, t22b_r, t31a_r, t31b_r, t32a_r, t32b_r;
  work_t b_cycr_r, b_cysr_r, b_sy_r, b_spcy_r, b_cpcy_r;
  // sums
  logic signed [SUMW-1:0] s_r [9];

  function automatic logic signed [FRAC_BITS+1:0] finish(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] r;
    logic signed [SUMW-1:0] lim;
    begin
      lim = SUMW'(1) <<< FRAC_BITS;
      r   = (v + (SUMW'(1) <<< (SH - 1))) >>> SH;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[OW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      spsy_r <= mul_q30(sp, sy);
      cpsy_r <= mul_q30(cp, sy);
      cycr_r <= mul_q30(cy, cr);
      cysr_r <= mul_q30(cy, sr);
      spcy_r <= mul_q30(sp, cy);
      cpcy_r <= mul_q30(cp, cy);
      a_sp_r <= sp; a_cp_r <= cp; a_sr_r <= sr; a_cr_r <= cr; a_sy_r <= sy;

      t21a_r <= mul_q30(spsy_r, a_cr_r);
      t21b_r <= mul_q30(a_cp_r, a_sr_r);
      t22a_r <= mul_q30(spsy_r, a_sr_r);
      t22b_r <= mul_q30(a_cp_r, a_cr_r);
      t31a_r <= mul_q30(cpsy_r, a_cr_r);
      t31b_r <= mul_q30(a_sp_r, a_sr_r);
      t32a_r <= mul_q30(cpsy_r, a_sr_r);
      t32b_r <= mul_q30(a_sp_r, a_cr_r);
      b_cycr_r <= cycr_r; b_cysr_r <= cysr_r; b_sy_r <= a_sy_r;
      b_spcy_r <= spcy_r; b_cpcy_r <= cpcy_r;

      s_r[0] <= SUMW'(b_cycr_r);
      s_r[1] <= SUMW'(b_cysr_r);
      s_r[2] <= SUMW'(b_sy_r);
      s_r[3] <= SUMW'(t21a_r) - SUMW'(t21b_r);
      s_r[4] <= SUMW'(t22a_r) + SUMW'(t22b_r);
      s_r[5] <= -SUMW'(b_spcy_r);
      s_r[6] <= -SUMW'(t31a_r) - SUMW'(t31b_r);
      s_r[7] <= -SUMW'(t32a_r) + SUMW'(t32b_r);
      s_r[8] <= SUMW'(b_cpcy_r);

      for (int k = 0; k < 9; k++) m_o[k] <= finish(s_r[k]);
    end
  end

endmodule
`default_nettype wire

FILE: design/euler_to_rotation_matrix_core.sv
// top level: euler angles to 3x3 rotation matrix, stalling pipeline
//
// channel | direction | payload
// in_     | input     | pitch, yaw, roll binary angles
// out_    | output    | m11..m33 in Q1.FRAC_BITS
//
// one item per cycle while the output is not stalled; 32 cordic stages (fold, 30 iterations,
// quadrant), then 4 product/sum/round stages
// reset clears the valid bits only; payload registers are not reset
// a stall at the output freezes the whole pipeline (global enable), so the
// output register holds and nothing is lost or repeated
`default_nettype none
module euler_to_rotation_matrix_core import e2r_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ANGLE_BITS-1:0]  in_pitch_angle,
  input  wire logic [ANGLE_BITS-1:0]  in_yaw_angle,
  input  wire logic [ANGLE_BITS-1:0]  in_roll_angle,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [FRAC_BITS+1:0] out_m11, out_m12, out_m13,
  output logic signed [FRAC_BITS+1:0] out_m21, out_m22, out_m23,
  output logic signed [FRAC_BITS+1:0] out_m31, out_m32, out_m33
);

  localparam int LAT = CORDIC_ITERS + 2 + 4;

  logic            en;
  logic [LAT-1:0]  vld_r;
  work_t           sp, cp, sy, cy, sr, cr;
  logic signed [FRAC_BITS+1:0] m [9];

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(in_pitch_angle), .sin_o(sp), .cos_o(cp));
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(in_yaw_angle), .sin_o(sy), .cos_o(cy));
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en), .angle(in_roll_angle), .sin_o(sr), .cos_o(cr));

  e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .en(en), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
    .m_o(m));

  assign out_m11 = m[0];
  assign out_m12 = m[1];
  assign out_m13 = m[2];
  assign out_m21 = m[3];
  assign out_m22 = m[4];
  assign out_m23 = m[5];
  assign out_m31 = m[6];
  assign out_m32 = m[7];
  assign out_m33 = m[8];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_m11) && $stable(out_m33))
    else $error("result changed under stall");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipeline stalled with empty output");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_m13 <= (1 <<< FRAC_BITS) && out_m13 >= -(1 <<< FRAC_BITS))
    else $error("entry out of range");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// testbench for the euler angle to rotation matrix core: scoreboard, stimulus and checks
`default_nettype none
module tb_top;
  import e2r_pkg::*;

  localparam int ANGLE_W = 16;
  localparam int MAT_W   = 16;
  localparam int N_RAND  = 1700;

  typedef struct {
    logic signed [MAT_W-1:0] m[9];
  } rot_mat_t;

  class rot_scoreboard;
    rot_mat_t pending_mats[$];
    int errors;
    int checked;

    // floor shift in 64 bits; >>> on signed longint floors
    function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
      return rnd_shift(a * b, WORK_FRAC);
    endfunction

    function automatic void trig(logic [ANGLE_W-1:0] ang, output longint s, output longint c);
      logic [31:0] phase;
      logic [1:0] quad;
      logic [31:0] zr;
      longint x, y, z, dx, dy;
      phase = {ang, 16'h0000};
      quad = 2'((phase + 32'h2000_0000) >> 30);
      zr = phase - {quad, 30'd0};
      z = longint'($signed(zr));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_phase(i));
        end else begin
          x += dx; y -= dy; z += longint'(atan_phase(i));
        end
      end
      case (quad)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function automatic logic signed [MAT_W-1:0] to_q14(longint v);
      longint r;
      r = rnd_shift(v, WORK_FRAC - 14);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return MAT_W'(r);
    endfunction

    function void note_angles(logic [ANGLE_W-1:0] p, logic [ANGLE_W-1:0] y,
                              logic [ANGLE_W-1:0] r);
      longint sp, cp, sy, cy, sr, cr, spsy, cpsy;
      rot_mat_t e;
      trig(p, sp, cp);
      trig(y, sy, cy);
      trig(r, sr, cr);
      spsy = qmul(sp, sy);
      cpsy = qmul(cp, sy);
      e.m[0] = to_q14(qmul(cy, cr));
      e.m[1] = to_q14(qmul(cy, sr));
      e.m[2] = to_q14(sy);
      e.m[3] = to_q14(qmul(spsy, cr) - qmul(cp, sr));
      e.m[4] = to_q14(qmul(spsy, sr) + qmul(cp, cr));
      e.m[5] = to_q14(-qmul(sp, cy));
      e.m[6] = to_q14(-qmul(cpsy, cr) - qmul(sp, sr));
      e.m[7] = to_q14(-qmul(cpsy, sr) + qmul(sp, cr));
      e.m[8] = to_q14(qmul(cp, cy));
      pending_mats.push_back(e);
    endfunction

    function void check_matrix(rot_mat_t got);
      rot_mat_t e;
      string nm[9] = '{"m11", "m12", "m13", "m21", "m22", "m23", "m31", "m32", "m33"};
      if (pending_mats.size() == 0) begin
        $error("matrix transfer with nothing expected");
        errors++;
        return;
      end
      e = pending_mats.pop_front();
      checked++;
      for (int k = 0; k < 9; k++)
        if (got.m[k] !== e.m[k]) begin
          $error("%s: expected %0d, got %0d", nm[k], e.m[k], got.m[k]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ANGLE_W-1:0] in_pitch_angle = '0, in_yaw_angle = '0, in_roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [MAT_W-1:0] out_m11, out_m12, out_m13, out_m21, out_m22, out_m23;
  logic signed [MAT_W-1:0] out_m31, out_m32, out_m33;

  rot_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stim_done = 1'b0;

  euler_to_rotation_matrix_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: stall at random, check each transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_matrix('{m: '{out_m11, out_m12, out_m13, out_m21, out_m22, out_m23,
                             out_m31, out_m32, out_m33}});
    if (rst_n)
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_angles(logic [ANGLE_W-1:0] p, logic [ANGLE_W-1:0] y,
                             logic [ANGLE_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pitch_angle <= p;
    in_yaw_angle <= y;
    in_roll_angle <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_angles(p, y, r);
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(3))
      0: return ANGLE_W'($urandom_range(3) * 16'h4000 + $urandom_range(8) - 4);
      1: return ANGLE_W'($urandom_range(7) * 16'h2000 + $urandom_range(2) - 1);
      default: return ANGLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [ANGLE_W-1:0] edge_ang[10];
    edge_ang = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000,
                 16'hC000, 16'h2000, 16'hE000, 16'h0001, 16'h5555};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, quadrant edges, octant ties and gimbal-lock yaw
    for (int i = 0; i < 10; i++)
      send_angles(edge_ang[i], edge_ang[(i + 3) % 10], edge_ang[(i + 7) % 10]);
    for (int i = 0; i < 8; i++)
      send_angles(ANGLE_W'($urandom), (i[0] ? 16'h4000 : 16'hC000), ANGLE_W'($urandom));
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 51 : 0;
      recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 37 : 0;
      for (int i = 0; i < N_RAND / 3; i++)
        send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    in_valid <= 1'b0;
    while (sb.pending_mats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d matrices: quadrant edges, gimbal lock, random angles", sb.checked);
    $display("stall mixes: sender-heavy, receiver-heavy and none");
    if (sb.errors == 0 && sb.pending_mats.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
